// ----- rtl/cpor_pkg.sv -----
// package for the circle pair overlap resolver: widths, payload structs, queue sizes
// and the coordinate saturation helper; depends on nothing
`timescale 1ns / 1ps

package cpor_pkg;

  localparam int ID_W      = 14;
  localparam int COORD_W   = 16;
  localparam int RAD_W     = 11;
  localparam int FRAC_BITS = 6;
  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(2 << FRAC_BITS);

  // a corrected pair has |dx|,|dy|,d <= 2*radius < 2^12, so dsq < 2^24
  localparam int MAG_W = RAD_W + 1;
  localparam int DSQ_W = 2 * MAG_W;
  localparam int NUM_W = 2 * MAG_W;
  localparam int REM_W = MAG_W + 2;

  localparam int MQ_DEPTH = 8;
  localparam int MQ_AW    = 3;
  localparam int OQ_DEPTH = 32;
  localparam int OQ_AW    = 5;

  typedef struct packed {
    logic [ID_W-1:0]    first_id;
    logic [ID_W-1:0]    second_id;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]    out_first_id;
    logic [ID_W-1:0]    out_second_id;
    logic [COORD_W-1:0] new_first_x;
    logic [COORD_W-1:0] new_first_y;
    logic [COORD_W-1:0] new_second_x;
    logic [COORD_W-1:0] new_second_y;
    logic               moved;
  } out_t;

  // classified transaction handed from the front to the back
  typedef struct packed {
    in_t              item;
    logic             corr;
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] adx;
    logic [MAG_W-1:0] ady;
    logic [DSQ_W-1:0] dsq;
  } mid_t;

  // clamp a signed coordinate to 0..65535
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [COORD_W+1:0] v);
    logic [COORD_W-1:0] r;
    if (v[COORD_W+1]) begin
      r = '0;
    end else if (v[COORD_W]) begin
      r = '1;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/cpor_front.sv -----
// front part: accepts transactions, forms |dx|, |dy|, dsq and decides whether the pair
// is corrected; three register stages; depends on cpor_pkg
`timescale 1ns / 1ps

module cpor_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cpor_pkg::RAD_W-1:0]  radius,
  input  logic                        acc,
  input  cpor_pkg::in_t               in_data,
  output logic                        mq_push,
  output cpor_pkg::mid_t              mq_data
);

  logic [cpor_pkg::MAG_W-1:0]     two_r;
  logic [cpor_pkg::DSQ_W-1:0]     limit_r;
  logic [cpor_pkg::COORD_W:0]     dx, dy, ndx, ndy;

  logic                           s1_v_r, s2_v_r, s3_v_r;
  cpor_pkg::in_t                  s1_item_r, s2_item_r;
  logic                           s1_nx_r, s1_ny_r, s2_nx_r, s2_ny_r;
  logic [cpor_pkg::COORD_W-1:0]   s1_adx_r, s1_ady_r, s2_adx_r, s2_ady_r;
  logic [2*cpor_pkg::COORD_W-1:0] s2_sqx_r, s2_sqy_r;
  logic [2*cpor_pkg::COORD_W:0]   dsq;
  cpor_pkg::mid_t                 s3_r;

  // squared contact distance, refreshed every cycle from the register
  assign two_r = {radius, 1'b0};
  always_ff @(posedge clk) begin
    limit_r <= two_r * two_r;
  end

  // signed differences and magnitudes
  assign dx  = {1'b0, in_data.second_x} - {1'b0, in_data.first_x};
  assign dy  = {1'b0, in_data.second_y} - {1'b0, in_data.first_y};
  assign ndx = '0 - dx;
  assign ndy = '0 - dy;

  assign dsq = {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    s1_item_r <= in_data;
    s1_nx_r   <= dx[cpor_pkg::COORD_W];
    s1_ny_r   <= dy[cpor_pkg::COORD_W];
    s1_adx_r  <= dx[cpor_pkg::COORD_W] ? ndx[cpor_pkg::COORD_W-1:0] : dx[cpor_pkg::COORD_W-1:0];
    s1_ady_r  <= dy[cpor_pkg::COORD_W] ? ndy[cpor_pkg::COORD_W-1:0] : dy[cpor_pkg::COORD_W-1:0];

    s2_item_r <= s1_item_r;
    s2_nx_r   <= s1_nx_r;
    s2_ny_r   <= s1_ny_r;
    s2_adx_r  <= s1_adx_r;
    s2_ady_r  <= s1_ady_r;
    s2_sqx_r  <= s1_adx_r * s1_adx_r;
    s2_sqy_r  <= s1_ady_r * s1_ady_r;

    s3_r.item  <= s2_item_r;
    s3_r.neg_x <= s2_nx_r;
    s3_r.neg_y <= s2_ny_r;
    s3_r.adx   <= s2_adx_r[cpor_pkg::MAG_W-1:0];
    s3_r.ady   <= s2_ady_r[cpor_pkg::MAG_W-1:0];
    s3_r.dsq   <= dsq[cpor_pkg::DSQ_W-1:0];
    s3_r.corr  <= (dsq <= {{(2*cpor_pkg::COORD_W+1-cpor_pkg::DSQ_W){1'b0}}, limit_r})
                  && (dsq != '0);
  end

  assign mq_push = s3_v_r;
  assign mq_data = s3_r;

endmodule

// ----- rtl/cpor_midq.sv -----
// short queue between front and back; 8 entries of classified transactions
// depends on cpor_pkg
`timescale 1ns / 1ps

module cpor_midq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cpor_pkg::mid_t wdata,
  input  logic           pop,
  output logic           empty,
  output cpor_pkg::mid_t rdata
);

  cpor_pkg::mid_t             mem_r [0:cpor_pkg::MQ_DEPTH-1];
  logic [cpor_pkg::MQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [cpor_pkg::MQ_AW:0]   cnt_r;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + {{cpor_pkg::MQ_AW{1'b0}}, push} - {{cpor_pkg::MQ_AW{1'b0}}, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

endmodule

// ----- rtl/cpor_back.sv -----
// back part: pipelined square root, offset multiply, two pipelined dividers, saturation
// and the result queue; depends on cpor_pkg
`timescale 1ns / 1ps

module cpor_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cpor_pkg::RAD_W-1:0]  radius,
  input  logic                        mq_empty,
  input  cpor_pkg::mid_t              mq_data,
  output logic                        mq_pop,
  input  logic                        pop,
  output logic                        empty,
  output cpor_pkg::out_t              out_data
);

  localparam int RS = cpor_pkg::MAG_W;
  localparam int DS = cpor_pkg::MAG_W;

  logic [cpor_pkg::OQ_AW:0] bcnt_r;
  logic                     out_acc;

  // square root stages
  logic                         rt_v   [0:RS];
  cpor_pkg::mid_t               rt_e   [0:RS];
  logic [cpor_pkg::DSQ_W-1:0]   rt_rem [0:RS];
  logic [cpor_pkg::DSQ_W-1:0]   rt_res [0:RS];

  // span and multiply stages
  logic                         sp_v_r, mu_v_r;
  cpor_pkg::mid_t               sp_e_r, mu_e_r;
  logic [cpor_pkg::MAG_W-1:0]   sp_d_r, sp_span_r, root, two_r;
  logic [cpor_pkg::MAG_W:0]     mu_den_r;
  logic [cpor_pkg::NUM_W-1:0]   mu_nx_r, mu_ny_r;

  // divider stages
  logic                         dv_v   [0:DS];
  cpor_pkg::mid_t               dv_e   [0:DS];
  logic [cpor_pkg::MAG_W:0]     dv_den [0:DS];
  logic [cpor_pkg::NUM_W-1:0]   dv_nx  [0:DS];
  logic [cpor_pkg::NUM_W-1:0]   dv_ny  [0:DS];
  logic [cpor_pkg::REM_W-1:0]   dv_px  [0:DS];
  logic [cpor_pkg::REM_W-1:0]   dv_py  [0:DS];
  logic [cpor_pkg::MAG_W-1:0]   dv_qx  [0:DS];
  logic [cpor_pkg::MAG_W-1:0]   dv_qy  [0:DS];

  // final stage and result queue
  logic                         fn_v_r;
  cpor_pkg::out_t               fn_r;
  cpor_pkg::mid_t               le;
  logic signed [cpor_pkg::COORD_W+1:0] mgx, mgy, fx, fy, sx, sy;
  cpor_pkg::out_t               oq_mem_r [0:cpor_pkg::OQ_DEPTH-1];
  logic [cpor_pkg::OQ_AW-1:0]   oq_wr_r, oq_rd_r;
  logic [cpor_pkg::OQ_AW:0]     oq_cnt_r;

  // take from the middle queue only when the result queue has room reserved
  assign mq_pop  = !mq_empty && (bcnt_r < (cpor_pkg::OQ_AW+1)'(cpor_pkg::OQ_DEPTH));
  assign out_acc = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= '0;
    end else begin
      bcnt_r <= bcnt_r + {{cpor_pkg::OQ_AW{1'b0}}, mq_pop}
                       - {{cpor_pkg::OQ_AW{1'b0}}, out_acc};
    end
  end

  // square root, one result bit per stage
  assign rt_v[0]   = mq_pop;
  assign rt_e[0]   = mq_data;
  assign rt_rem[0] = mq_data.dsq;
  assign rt_res[0] = '0;

  for (genvar k = 0; k < RS; k++) begin : g_root
    localparam logic [cpor_pkg::DSQ_W-1:0] BIT =
      cpor_pkg::DSQ_W'(1) << (cpor_pkg::DSQ_W - 2 - 2*k);
    logic [cpor_pkg::DSQ_W-1:0] trial;
    assign trial = rt_res[k] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v[k+1] <= 1'b0;
      end else begin
        rt_v[k+1] <= rt_v[k];
      end
    end

    always_ff @(posedge clk) begin
      rt_e[k+1] <= rt_e[k];
      if (rt_rem[k] >= trial) begin
        rt_rem[k+1] <= rt_rem[k] - trial;
        rt_res[k+1] <= (rt_res[k] >> 1) + BIT;
      end else begin
        rt_rem[k+1] <= rt_rem[k];
        rt_res[k+1] <= rt_res[k] >> 1;
      end
    end
  end

  // span = 2r - d, then numerators |delta|*span + d and divisor 2d
  assign root  = rt_res[RS][cpor_pkg::MAG_W-1:0];
  assign two_r = {radius, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_v_r <= 1'b0;
      mu_v_r <= 1'b0;
    end else begin
      sp_v_r <= rt_v[RS];
      mu_v_r <= sp_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sp_e_r    <= rt_e[RS];
    sp_d_r    <= root;
    sp_span_r <= (two_r >= root) ? (two_r - root) : '0;
    mu_e_r    <= sp_e_r;
    mu_den_r  <= {sp_d_r, 1'b0};
    mu_nx_r   <= sp_e_r.adx * sp_span_r + {{cpor_pkg::MAG_W{1'b0}}, sp_d_r};
    mu_ny_r   <= sp_e_r.ady * sp_span_r + {{cpor_pkg::MAG_W{1'b0}}, sp_d_r};
  end

  // restoring dividers for x and y, one quotient bit per stage
  assign dv_v[0]   = mu_v_r;
  assign dv_e[0]   = mu_e_r;
  assign dv_den[0] = mu_den_r;
  assign dv_nx[0]  = mu_nx_r;
  assign dv_ny[0]  = mu_ny_r;
  assign dv_px[0]  = {2'b00, mu_nx_r[cpor_pkg::NUM_W-1:cpor_pkg::MAG_W]};
  assign dv_py[0]  = {2'b00, mu_ny_r[cpor_pkg::NUM_W-1:cpor_pkg::MAG_W]};
  assign dv_qx[0]  = '0;
  assign dv_qy[0]  = '0;

  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int NB = cpor_pkg::MAG_W - 1 - j;
    logic [cpor_pkg::REM_W-1:0] shx, shy, den;
    assign shx = {dv_px[j][cpor_pkg::REM_W-2:0], dv_nx[j][NB]};
    assign shy = {dv_py[j][cpor_pkg::REM_W-2:0], dv_ny[j][NB]};
    assign den = {1'b0, dv_den[j]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[j+1] <= 1'b0;
      end else begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_e[j+1]   <= dv_e[j];
      dv_den[j+1] <= dv_den[j];
      dv_nx[j+1]  <= dv_nx[j];
      dv_ny[j+1]  <= dv_ny[j];
      dv_px[j+1]  <= (shx >= den) ? (shx - den) : shx;
      dv_py[j+1]  <= (shy >= den) ? (shy - den) : shy;
      dv_qx[j+1]  <= {dv_qx[j][cpor_pkg::MAG_W-2:0], shx >= den};
      dv_qy[j+1]  <= {dv_qy[j][cpor_pkg::MAG_W-2:0], shy >= den};
    end
  end

  // apply offsets in opposite directions and saturate
  assign le  = dv_e[DS];
  assign mgx = {6'd0, dv_qx[DS]};
  assign mgy = {6'd0, dv_qy[DS]};
  assign fx  = le.neg_x ? {2'b00, le.item.first_x} + mgx : {2'b00, le.item.first_x} - mgx;
  assign fy  = le.neg_y ? {2'b00, le.item.first_y} + mgy : {2'b00, le.item.first_y} - mgy;
  assign sx  = le.neg_x ? {2'b00, le.item.second_x} - mgx : {2'b00, le.item.second_x} + mgx;
  assign sy  = le.neg_y ? {2'b00, le.item.second_y} - mgy : {2'b00, le.item.second_y} + mgy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fn_v_r <= 1'b0;
    end else begin
      fn_v_r <= dv_v[DS];
    end
  end

  always_ff @(posedge clk) begin
    fn_r.out_first_id  <= le.item.first_id;
    fn_r.out_second_id <= le.item.second_id;
    fn_r.moved         <= le.corr;
    if (le.corr) begin
      fn_r.new_first_x  <= cpor_pkg::sat_coord(fx);
      fn_r.new_first_y  <= cpor_pkg::sat_coord(fy);
      fn_r.new_second_x <= cpor_pkg::sat_coord(sx);
      fn_r.new_second_y <= cpor_pkg::sat_coord(sy);
    end else begin
      fn_r.new_first_x  <= le.item.first_x;
      fn_r.new_first_y  <= le.item.first_y;
      fn_r.new_second_x <= le.item.second_x;
      fn_r.new_second_y <= le.item.second_y;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (fn_v_r)  oq_wr_r <= oq_wr_r + 1'b1;
      if (out_acc) oq_rd_r <= oq_rd_r + 1'b1;
      oq_cnt_r <= oq_cnt_r + {{cpor_pkg::OQ_AW{1'b0}}, fn_v_r}
                           - {{cpor_pkg::OQ_AW{1'b0}}, out_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (fn_v_r) oq_mem_r[oq_wr_r] <= fn_r;
  end

  assign empty    = (oq_cnt_r == '0);
  assign out_data = oq_mem_r[oq_rd_r];

`ifndef SYNTH
  a_bcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= (cpor_pkg::OQ_AW+1)'(cpor_pkg::OQ_DEPTH))
    else $error("back occupancy above result queue depth");

  a_oq_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= bcnt_r)
    else $error("result queue holds more than was reserved");

  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fn_v_r |-> (oq_cnt_r < (cpor_pkg::OQ_AW+1)'(cpor_pkg::OQ_DEPTH)) || out_acc)
    else $error("result written into a full queue");
`endif

endmodule

// ----- rtl/circle_pair_overlap_resolver.sv -----
// top level of the circle pair overlap resolver: radius register, admission control,
// front, middle queue and back; depends on cpor_pkg, cpor_front, cpor_midq, cpor_back
`timescale 1ns / 1ps

// Resolves the overlap of two equal circles in unsigned Q10.6: a pair whose squared
// distance is at most (2*radius)^2 and not zero is pushed apart along the centre line,
// otherwise it passes through with moved low. One transaction is taken every cycle while
// full is low, and one result leaves every cycle while pop is held and empty is low. A
// transaction passes from push to the result ports through 3 front stages (difference,
// squares, compare), then after the middle queue 12 square root stages, a span and a
// multiply stage, 12 divider stages for each axis and a saturation stage. full rises
// only when the 8-entry middle queue is reserved, which happens once the back is stalled
// because all 32 entries of the result queue are reserved. The radius must be written
// by the user only while no transaction is in flight; the block does not enforce this.
module circle_pair_overlap_resolver (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [cpor_pkg::RAD_W-1:0] cfg_wdata,
  input  logic                       push,
  output logic                       full,
  input  cpor_pkg::in_t              in_data,
  input  logic                       pop,
  output logic                       empty,
  output cpor_pkg::out_t             out_data
);

  logic [cpor_pkg::RAD_W-1:0] radius_r;
  logic [cpor_pkg::MQ_AW:0]   fcnt_r;
  logic                       acc, mq_push, mq_pop, mq_empty;
  cpor_pkg::mid_t             mq_wdata, mq_rdata;

  // radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= cpor_pkg::RADIUS_RST;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // front admission: transactions in the front plus the middle queue
  assign acc  = push && !full;
  assign full = (fcnt_r == (cpor_pkg::MQ_AW+1)'(cpor_pkg::MQ_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= '0;
    end else begin
      fcnt_r <= fcnt_r + {{cpor_pkg::MQ_AW{1'b0}}, acc} - {{cpor_pkg::MQ_AW{1'b0}}, mq_pop};
    end
  end

  cpor_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .radius  (radius_r),
    .acc     (acc),
    .in_data (in_data),
    .mq_push (mq_push),
    .mq_data (mq_wdata)
  );

  cpor_midq u_midq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .pop   (mq_pop),
    .empty (mq_empty),
    .rdata (mq_rdata)
  );

  cpor_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .radius   (radius_r),
    .mq_empty (mq_empty),
    .mq_data  (mq_rdata),
    .mq_pop   (mq_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

`ifndef SYNTH
  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= (cpor_pkg::MQ_AW+1)'(cpor_pkg::MQ_DEPTH))
    else $error("front occupancy above middle queue depth");

  a_mq_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mq_pop |-> !mq_empty)
    else $error("middle queue popped while empty");

  a_mq_pop_credit: assert property (@(posedge clk) disable iff (!rst_n)
    mq_pop |-> (fcnt_r != '0))
    else $error("middle queue pop without a counted transaction");
`endif

endmodule

// ----- bench/circle_pair_overlap_resolver_test.sv -----
// testbench for the circle pair overlap resolver: predicts each corrected pair,
// drives directed and random pairs under idling and stalls; depends on cpor_pkg and the rtl
`timescale 1ns / 1ps

module circle_pair_overlap_resolver_test;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [cpor_pkg::RAD_W-1:0] cfg_wdata;
  logic push;
  logic full;
  cpor_pkg::in_t in_data;
  logic pop;
  logic empty;
  cpor_pkg::out_t out_data;

  logic [cpor_pkg::RAD_W-1:0] radius_q;
  cpor_pkg::out_t pending_pairs[$];
  int mismatches;
  int sender_idle_pct;
  int receiver_idle_pct;
  int hold_cycles;

  circle_pair_overlap_resolver dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .in_data(in_data),
    .pop(pop), .empty(empty), .out_data(out_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // integer square root, floor
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint offset_along(input longint delta, input longint unsigned span,
                                          input longint unsigned root_d);
    longint unsigned mag;
    mag = ((delta < 0 ? -delta : delta) * span + root_d) / (2 * root_d);
    return delta < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [cpor_pkg::COORD_W-1:0] clamp16(input longint v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[cpor_pkg::COORD_W-1:0];
  endfunction

  // expected separated pair for one transaction
  function automatic cpor_pkg::out_t separate_pair(input cpor_pkg::in_t p,
                                                   input logic [cpor_pkg::RAD_W-1:0] rad);
    cpor_pkg::out_t r;
    longint fx, fy, sx, sy, dx, dy, px, py;
    longint unsigned dsq, two_r, root_d, span;
    fx = p.first_x; fy = p.first_y; sx = p.second_x; sy = p.second_y;
    dx = sx - fx; dy = sy - fy;
    dsq = dx * dx + dy * dy;
    two_r = 2 * rad;
    r.out_first_id = p.first_id;
    r.out_second_id = p.second_id;
    r.moved = 1'b0;
    if (dsq <= two_r * two_r && dsq != 0) begin
      root_d = floor_sqrt(dsq);
      span = two_r >= root_d ? two_r - root_d : 0;
      px = offset_along(dx, span, root_d);
      py = offset_along(dy, span, root_d);
      fx -= px; fy -= py; sx += px; sy += py;
      r.moved = 1'b1;
    end
    r.new_first_x = clamp16(fx);
    r.new_first_y = clamp16(fy);
    r.new_second_x = clamp16(sx);
    r.new_second_y = clamp16(sy);
    return r;
  endfunction

  // send one transaction and record its expected result; push stays high for the next one
  task automatic send_pair(input cpor_pkg::in_t p);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_pairs.push_back(separate_pair(p, radius_q));
    @(negedge clk);
  endtask

  // receiver: pop with random idling, long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= $urandom_range(99) >= receiver_idle_pct;
    end
  end

  // result checker
  always @(posedge clk) begin
    cpor_pkg::out_t exp_r;
    if (rst_n && pop && !empty) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        mismatches++;
      end else begin
        exp_r = pending_pairs.pop_front();
        if (out_data.out_first_id !== exp_r.out_first_id ||
            out_data.out_second_id !== exp_r.out_second_id ||
            out_data.new_first_x !== exp_r.new_first_x ||
            out_data.new_first_y !== exp_r.new_first_y ||
            out_data.new_second_x !== exp_r.new_second_x ||
            out_data.new_second_y !== exp_r.new_second_y ||
            out_data.moved !== exp_r.moved) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_data);
          mismatches++;
        end
      end
    end
  end

  // stop offering and wait until every expected result has come
  task automatic drain;
    push <= 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_radius(input logic [cpor_pkg::RAD_W-1:0] r);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    radius_q = r;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic cpor_pkg::in_t make_pair(input int fx, input int fy, input int sx,
                                              input int sy);
    cpor_pkg::in_t p;
    p.first_id = (cpor_pkg::ID_W)'($urandom);
    p.second_id = (cpor_pkg::ID_W)'($urandom);
    p.first_x = (cpor_pkg::COORD_W)'(fx);
    p.first_y = (cpor_pkg::COORD_W)'(fy);
    p.second_x = (cpor_pkg::COORD_W)'(sx);
    p.second_y = (cpor_pkg::COORD_W)'(sy);
    return p;
  endfunction

  // random pair, mostly near each other relative to the radius
  function automatic cpor_pkg::in_t random_pair();
    cpor_pkg::in_t p;
    int spread;
    p = make_pair($urandom, $urandom, 0, 0);
    spread = 2 * radius_q + 4;
    if ($urandom_range(9) < 8) begin
      p.second_x = (cpor_pkg::COORD_W)'(int'(p.first_x) +
                                        int'($urandom_range(2 * spread)) - spread);
      p.second_y = (cpor_pkg::COORD_W)'(int'(p.first_y) +
                                        int'($urandom_range(2 * spread)) - spread);
    end else begin
      p.second_x = (cpor_pkg::COORD_W)'($urandom);
      p.second_y = (cpor_pkg::COORD_W)'($urandom);
    end
    return p;
  endfunction

  // directed special cases at the reset radius
  task automatic test_special_cases;
    int r2;
    r2 = 2 * radius_q;
    send_pair(make_pair(1000, 1000, 1000 + r2 + 1, 1000));
    send_pair(make_pair(1000, 1000, 1000 + r2, 1000));
    send_pair(make_pair(5000, 5000, 5000, 5000 + r2));
    send_pair(make_pair(3000, 3000, 3000, 3000));
    send_pair(make_pair(3000, 3000, 3000 + r2 - 1, 3000));
    send_pair(make_pair(3000, 3000, 3001, 3000));
    send_pair(make_pair(3000, 3000, 2999, 2999));
    send_pair(make_pair(0, 0, 10, 10));
    send_pair(make_pair(65535, 65535, 65525, 65520));
    send_pair(make_pair(0, 65535, 0, 65535));
    send_pair(make_pair(65535, 0, 0, 65535));
    send_pair(make_pair(0, 0, 65535, 65535));
    send_pair(make_pair(100, 200, 130, 240));
    send_pair('1);
    send_pair('0);
  endtask

  // radius extremes, including the largest value, one and zero
  task automatic test_radius_extremes;
    logic [cpor_pkg::RAD_W-1:0] rads[5];
    rads = '{11'd64, 11'd1024, 11'd2047, 11'd0, 11'd1};
    foreach (rads[i]) begin
      set_radius(rads[i]);
      send_pair(make_pair(20000, 20000, 20000 + rads[i], 20000));
      send_pair(make_pair(0, 0, 1, 1));
      repeat (10) send_pair(random_pair());
    end
  endtask

  task automatic test_random_block(input int count);
    repeat (count) send_pair(random_pair());
  endtask

  // stall the receiver long enough to fill the block, then let it drain
  task automatic test_backpressure;
    hold_cycles = 200;
    repeat (60) send_pair(random_pair());
    drain();
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0; push = 1'b0; in_data = '0;
    mismatches = 0; hold_cycles = 0;
    sender_idle_pct = 0; receiver_idle_pct = 0;
    radius_q = cpor_pkg::RADIUS_RST;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_special_cases();
    test_radius_extremes();
    set_radius(11'd128);
    sender_idle_pct = 32; receiver_idle_pct = 78;
    test_random_block(300);
    set_radius(11'd600);
    sender_idle_pct = 78; receiver_idle_pct = 32;
    test_random_block(300);
    set_radius(11'd90);
    sender_idle_pct = 0; receiver_idle_pct = 0;
    test_random_block(300);
    test_backpressure();
    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
